### rtl/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg
// Shared types and constants of the linear interpolation resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

    localparam int MAX_CHANNELS_DEF    = 8;
    localparam int PHASE_FRAC_BITS_DEF = 16;
    localparam int MAX_RESULTS         = 64;
    localparam int SAMPLE_W            = 16;
    localparam int CHAN_W              = 3;
    localparam int COUNT_W             = 4;
    localparam int RESULT_CNT_W        = 7;
    localparam int Q_DEPTH             = 2;
    localparam int CFG_IDX_W           = 1;

    localparam logic [COUNT_W-1:0]   CH_COUNT_RESET    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_RATIO    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

### rtl/lir_if.sv
// ----------------------------------------------------------------------------
// lir_if
// Valid/ready channels for input samples and interpolated results.
// ----------------------------------------------------------------------------
interface lir_sample_if
    import lir_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface lir_result_if
    import lir_pkg::*;
();
    logic              valid;
    logic              ready;
    sample_t           out_sample;
    logic [CHAN_W-1:0] channel;
    logic              last;

    modport source (output valid, output out_sample, output channel, output last,
                    input ready);
    modport sink   (input valid, input out_sample, input channel, input last,
                    output ready);
endinterface

### rtl/lir_front.sv
// ----------------------------------------------------------------------------
// lir_front
// Accepts samples, keeps the two most recent frames and posts a burst job
// whenever a frame completes after the first one.
// ----------------------------------------------------------------------------
module lir_front
    import lir_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [COUNT_W-1:0] channel_count,
    lir_sample_if.sink         samples,
    input  q_status_t          q_status,
    output logic               push,
    output sample_t            push_older [MAX_CHANNELS],
    output sample_t            push_newer [MAX_CHANNELS],
    output logic [COUNT_W-1:0] push_count
);

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    sample_t           older_reg [MAX_CHANNELS];
    sample_t           newer_reg [MAX_CHANNELS];
    sample_t           older_next [MAX_CHANNELS];
    sample_t           newer_next [MAX_CHANNELS];
    logic [CHAN_W-1:0] chpos_reg;
    logic [CHAN_W-1:0] chpos_next;
    logic [1:0]        seen_reg;
    logic [1:0]        seen_next;
    logic [COUNT_W-1:0] count_eff;
    logic              accept;
    logic              complete;

    assign samples.ready = !q_status.full;
    assign accept        = samples.valid && samples.ready;

    always_comb
    begin
        if (channel_count == '0)
        begin
            count_eff = COUNT_W'(1);
        end
        else if (channel_count > COUNT_W'(MAX_CHANNELS))
        begin
            count_eff = COUNT_W'(MAX_CHANNELS);
        end
        else
        begin
            count_eff = channel_count;
        end
    end

    assign complete = (COUNT_W'(chpos_reg) + COUNT_W'(1)) >= count_eff;

    always_comb
    begin
        older_next = older_reg;
        newer_next = newer_reg;
        if (COUNT_W'(chpos_reg) < COUNT_W'(MAX_CHANNELS))
        begin
            older_next[chpos_reg[IDX_W-1:0]] = newer_reg[chpos_reg[IDX_W-1:0]];
            newer_next[chpos_reg[IDX_W-1:0]] = samples.sample;
        end
        chpos_next = complete ? '0 : chpos_reg + CHAN_W'(1);
        seen_next  = (complete && seen_reg != 2'd2) ? seen_reg + 2'd1 : seen_reg;
    end

    assign push       = accept && complete && (seen_reg != 2'd0);
    assign push_older = older_next;
    assign push_newer = newer_next;
    assign push_count = count_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                older_reg[i] <= '0;
                newer_reg[i] <= '0;
            end
            chpos_reg <= '0;
            seen_reg  <= '0;
        end
        else if (accept)
        begin
            older_reg <= older_next;
            newer_reg <= newer_next;
            chpos_reg <= chpos_next;
            seen_reg  <= seen_next;
        end
    end

endmodule

### rtl/lir_queue.sv
// ----------------------------------------------------------------------------
// lir_queue
// Two-entry job queue holding frame snapshots between front and back end.
// ----------------------------------------------------------------------------
module lir_queue
    import lir_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sample_t            push_older [MAX_CHANNELS],
    input  sample_t            push_newer [MAX_CHANNELS],
    input  logic [COUNT_W-1:0] push_count,
    input  logic               pop,
    output sample_t            head_older [MAX_CHANNELS],
    output sample_t            head_newer [MAX_CHANNELS],
    output logic [COUNT_W-1:0] head_count,
    output q_status_t          status
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    sample_t            older_mem [Q_DEPTH][MAX_CHANNELS];
    sample_t            newer_mem [Q_DEPTH][MAX_CHANNELS];
    logic [COUNT_W-1:0] count_mem [Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   fill_reg;

    assign status.full  = (fill_reg == CNT_W'(Q_DEPTH));
    assign status.empty = (fill_reg == '0);
    assign head_older   = older_mem[rd_ptr_reg];
    assign head_newer   = newer_mem[rd_ptr_reg];
    assign head_count   = count_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            older_mem[wr_ptr_reg] <= push_older;
            newer_mem[wr_ptr_reg] <= push_newer;
            count_mem[wr_ptr_reg] <= push_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

endmodule

### rtl/lir_back.sv
// ----------------------------------------------------------------------------
// lir_back
// Runs at most one burst per job: steps the position accumulator and
// interpolates each channel of each frame in one shared multiply stage.
// ----------------------------------------------------------------------------
module lir_back
    import lir_pkg::*;
#(
    parameter int MAX_CHANNELS    = MAX_CHANNELS_DEF,
    parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [PHASE_FRAC_BITS+4:0] step_ratio,
    input  q_status_t                  q_status,
    input  sample_t                    head_older [MAX_CHANNELS],
    input  sample_t                    head_newer [MAX_CHANNELS],
    input  logic [COUNT_W-1:0]         head_count,
    output logic                       pop,
    lir_result_if.source               results
);

    localparam int PF    = PHASE_FRAC_BITS;
    localparam int ACC_W = PF + 5;
    localparam int POS_W = ACC_W + 1;
    localparam int PROD_W = PF + 18;
    localparam int SUM_W = PF + 19;
    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam logic [POS_W-1:0] ONE = POS_W'(1) << PF;
    localparam logic [POS_W-1:0] ACC_MAX = POS_W'({ACC_W{1'b1}});

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic [ACC_W-1:0]        acc_reg;
    logic [ACC_W-1:0]        acc_next;
    logic [POS_W-1:0]        pos_reg;
    logic [POS_W-1:0]        pos_next;
    logic [RESULT_CNT_W-1:0] n_reg;
    logic [RESULT_CNT_W-1:0] n_next;
    logic [CHAN_W-1:0]       j_reg;
    logic [CHAN_W-1:0]       j_next;
    logic                    last_reg;
    logic                    last_next;
    logic signed [PROD_W-1:0] prod_a_reg;
    logic signed [PROD_W-1:0] prod_b_reg;
    sample_t                 out_sample_reg;
    sample_t                 out_sample_next;

    logic [POS_W-1:0]        pos_sum;
    logic [PF-1:0]           frac;
    logic                    frame_end;
    logic                    cont;
    logic [RESULT_CNT_W:0]   n_frame;
    logic signed [SUM_W-1:0] sum;
    logic [SUM_W-1:0]        mag;
    logic [SUM_W-1:0]        quot;
    logic [SUM_W-1:0]        res;

    function automatic logic [ACC_W-1:0] settle(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] r;
        r = (p >= ONE) ? p - ONE : '0;
        if (r > ACC_MAX)
        begin
            r = ACC_MAX;
        end
        return r[ACC_W-1:0];
    endfunction

    assign pos_sum     = pos_reg + POS_W'(step_ratio);
    assign frac        = pos_reg[PF-1:0];
    assign frame_end   = ({1'b0, j_reg} + COUNT_W'(1)) == head_count;
    assign n_frame     = (RESULT_CNT_W+1)'(n_reg) + (RESULT_CNT_W+1)'(head_count);
    assign cont        = (pos_sum < ONE)
                         && ((n_frame + (RESULT_CNT_W+1)'(head_count))
                             <= (RESULT_CNT_W+1)'(MAX_RESULTS));

    logic [POS_W-1:0] weight_a;
    assign weight_a = ONE - pos_reg;

    assign sum  = SUM_W'(prod_a_reg) + SUM_W'(prod_b_reg);
    assign mag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    assign quot = mag >> PF;
    assign res  = sum[SUM_W-1] ? -quot : quot;

    assign pop                = (state_reg == ST_IDLE && !q_status.empty
                                 && POS_W'(acc_reg) >= ONE)
                                || (state_reg == ST_OUT && results.ready && frame_end && !cont);
    assign results.valid      = (state_reg == ST_OUT);
    assign results.out_sample = out_sample_reg;
    assign results.channel    = j_reg;
    assign results.last       = last_reg;

    always_comb
    begin
        state_next      = state_reg;
        acc_next        = acc_reg;
        pos_next        = pos_reg;
        n_next          = n_reg;
        j_next          = j_reg;
        last_next       = last_reg;
        out_sample_next = out_sample_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    if (POS_W'(acc_reg) >= ONE)
                    begin
                        acc_next = settle(POS_W'(acc_reg));
                    end
                    else
                    begin
                        pos_next   = POS_W'(acc_reg);
                        n_next     = '0;
                        j_next     = '0;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                last_next  = frame_end && !cont;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                out_sample_next = res[SAMPLE_W-1:0];
                state_next      = ST_OUT;
            end
            ST_OUT:
            begin
                if (results.ready)
                begin
                    if (!frame_end)
                    begin
                        j_next     = j_reg + CHAN_W'(1);
                        state_next = ST_MUL;
                    end
                    else if (cont)
                    begin
                        j_next     = '0;
                        n_next     = n_frame[RESULT_CNT_W-1:0];
                        pos_next   = pos_sum;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        acc_next   = settle(pos_sum);
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            prod_a_reg <= PROD_W'(head_older[j_reg[IDX_W-1:0]])
                          * PROD_W'($signed({1'b0, weight_a[PF:0]}));
            prod_b_reg <= PROD_W'(head_newer[j_reg[IDX_W-1:0]])
                          * PROD_W'($signed({2'b0, frac}));
        end
        out_sample_reg <= out_sample_next;
        pos_reg        <= pos_next;
        n_reg          <= n_next;
        j_reg          <= j_next;
        last_reg       <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            acc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

### rtl/linear_interp_audio_resampler.sv
// ----------------------------------------------------------------------------
// linear_interp_audio_resampler
// Linear interpolation sample rate converter for interleaved 16-bit audio.
//
//   Channel   Dir   Handshake     Payload
//   samples   in    valid/ready   sample (signed 16)
//   results   out   valid/ready   out_sample (signed 16), channel (3), last
//   cfg       in    cfg_we        cfg_index selects step_ratio or channel_count
//
// A sample is taken while the job queue has room.
// Each result word passes through the shared multiply and sum stages and the
// output state; each job is first taken up from the queue in the idle state.
// A stalled result holds the back end; the front end keeps taking samples
// until two completed frames wait in the queue.
// Reset clears the frames, the accumulator and the queue at once.
// ----------------------------------------------------------------------------
module linear_interp_audio_resampler
    import lir_pkg::*;
#(
    parameter int MAX_CHANNELS    = MAX_CHANNELS_DEF,
    parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [PHASE_FRAC_BITS+4:0] cfg_data,
    lir_sample_if.sink                 samples,
    lir_result_if.source               results
);

    localparam int ACC_W = PHASE_FRAC_BITS + 5;

    logic [ACC_W-1:0]   step_ratio_reg;
    logic [COUNT_W-1:0] channel_count_reg;

    logic               push;
    logic               pop;
    q_status_t          q_status;
    sample_t            push_older [MAX_CHANNELS];
    sample_t            push_newer [MAX_CHANNELS];
    logic [COUNT_W-1:0] push_count;
    sample_t            head_older [MAX_CHANNELS];
    sample_t            head_newer [MAX_CHANNELS];
    logic [COUNT_W-1:0] head_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_ratio_reg    <= ACC_W'(1) << PHASE_FRAC_BITS;
            channel_count_reg <= CH_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STEP_RATIO:    step_ratio_reg    <= cfg_data;
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    lir_front #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .channel_count (channel_count_reg),
        .samples       (samples),
        .q_status      (q_status),
        .push          (push),
        .push_older    (push_older),
        .push_newer    (push_newer),
        .push_count    (push_count)
    );

    lir_queue #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_older (push_older),
        .push_newer (push_newer),
        .push_count (push_count),
        .pop        (pop),
        .head_older (head_older),
        .head_newer (head_newer),
        .head_count (head_count),
        .status     (q_status)
    );

    lir_back #(
        .MAX_CHANNELS    (MAX_CHANNELS),
        .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_ratio (step_ratio_reg),
        .q_status   (q_status),
        .head_older (head_older),
        .head_newer (head_newer),
        .head_count (head_count),
        .pop        (pop),
        .results    (results)
    );

endmodule

### rtl/lir_checker.sv
// ----------------------------------------------------------------------------
// lir_checker
// Port-level checks on the resampler's result stream and input flow control.
// ----------------------------------------------------------------------------
module lir_checker
    import lir_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              samples_valid,
    input logic              samples_ready,
    input logic              results_valid,
    input logic              results_ready,
    input sample_t           results_out_sample,
    input logic [CHAN_W-1:0] results_channel,
    input logic              results_last
);

    logic [CHAN_W-1:0] prev_ch_reg;
    logic              prev_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_ch_reg   <= '0;
            prev_last_reg <= 1'b1;
        end
        else if (results_valid && results_ready)
        begin
            prev_ch_reg   <= results_channel;
            prev_last_reg <= results_last;
        end
    end

    // A burst starts at channel zero and steps through the channels in order.
    a_channel_order: assert property (@(posedge clk) disable iff (!rst_n)
        results_valid |-> (prev_last_reg ? (results_channel == '0)
                                         : (results_channel == '0
                                            || results_channel == prev_ch_reg + CHAN_W'(1))))
        else $error("result channel out of order");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        results_valid && !results_ready |=> results_valid
            && $stable(results_out_sample) && $stable(results_channel)
            && $stable(results_last))
        else $error("stalled result word changed");

    // The queue only fills when a sample is taken.
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(samples_ready) |-> $past(samples_valid))
        else $error("input ready dropped without a sample taken");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !results_valid)
        else $error("result word right after reset");

endmodule

bind linear_interp_audio_resampler lir_checker u_lir_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .samples_valid      (samples.valid),
    .samples_ready      (samples.ready),
    .results_valid      (results.valid),
    .results_ready      (results.ready),
    .results_out_sample (results.out_sample),
    .results_channel    (results.channel),
    .results_last       (results.last)
);

### sim/tb_linear_interp_audio_resampler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_linear_interp_audio_resampler
// Self-checking testbench for the linear interpolation resampler. Samples
// go in through the valid/ready input in random bursts with random gaps if
// enabled. A local model of the frame store and the position accumulator
// works out every interpolated word. Each result word is checked in order
// against that model while the result side stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_linear_interp_audio_resampler
    import lir_pkg::*;
();

    localparam int               CFG_W         = PHASE_FRAC_BITS_DEF + 5;
    localparam logic [CFG_W-1:0] STEP_MAX      = '1;
    localparam longint           UNITY         = longint'(1) << PHASE_FRAC_BITS_DEF;
    localparam longint           ACC_LIMIT     = longint'(STEP_MAX);
    localparam int               SETTLE_CYCLES = 32;
    localparam int               TAIL_CYCLES   = 3 * MAX_RESULTS + 16;
    localparam int               LONG_HOLD     = 400;
    localparam int               RANDOM_ITEMS  = 110;
    localparam int               TIMEOUT_NS    = 5_000_000;
    localparam sample_t          S_MAX         = 16'sh7FFF;
    localparam sample_t          S_MIN         = 16'sh8000;

    typedef struct {
        sample_t           value;
        logic [CHAN_W-1:0] chan;
        logic              last;
    } interp_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    lir_sample_if smp_if ();
    lir_result_if res_if ();

    linear_interp_audio_resampler i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (smp_if),
        .results   (res_if)
    );

    logic [CFG_W-1:0]   step_ratio_q;
    logic [COUNT_W-1:0] channel_count_q;
    sample_t            older_frame_q [MAX_CHANNELS_DEF];
    sample_t            newer_frame_q [MAX_CHANNELS_DEF];
    logic [CHAN_W-1:0]  chan_pos_q;
    logic [CFG_W-1:0]   position_q;
    logic [1:0]         frames_q;
    interp_word_t       pending_words [$];
    int                 error_count;
    int                 hold_request;
    int                 burst_left;
    bit                 gaps_on;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic sample_t lerp_sample(sample_t a, sample_t b, longint frac);
        longint sum;
        sum = longint'(a) * (UNITY - frac) + longint'(b) * frac;
        if (sum < 0)
            return sample_t'(-((-sum) >>> PHASE_FRAC_BITS_DEF));
        return sample_t'(sum >>> PHASE_FRAC_BITS_DEF);
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3:       return '1;
            default: return sample_t'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // Mirrors the frame store and accumulator; queues the words of a frame end.
    task automatic predict_words(sample_t smp);
        int           eff;
        int           c;
        int           n;
        int           j;
        bit           final_frame;
        longint       pos;
        interp_word_t w;
        if (channel_count_q == 0)
            eff = 1;
        else if (channel_count_q > MAX_CHANNELS_DEF)
            eff = MAX_CHANNELS_DEF;
        else
            eff = int'(channel_count_q);
        c = int'(chan_pos_q);
        older_frame_q[c] = newer_frame_q[c];
        newer_frame_q[c] = smp;
        if (c + 1 < eff)
        begin
            chan_pos_q = CHAN_W'(c + 1);
            return;
        end
        chan_pos_q = '0;
        if (frames_q < 2)
            frames_q++;
        if (frames_q < 2)
            return;
        pos = longint'(position_q);
        n   = 0;
        while (pos < UNITY && n + eff <= MAX_RESULTS)
        begin
            final_frame = !((pos + longint'(step_ratio_q) < UNITY) &&
                            (n + 2 * eff <= MAX_RESULTS));
            for (j = 0; j < eff; j++)
            begin
                w.value = lerp_sample(older_frame_q[j], newer_frame_q[j], pos);
                w.chan  = CHAN_W'(j);
                w.last  = final_frame && (j == eff - 1);
                pending_words.push_back(w);
                n++;
            end
            pos += longint'(step_ratio_q);
        end
        if (pos >= UNITY)
            pos -= UNITY;
        else
            pos = 0;
        if (pos > ACC_LIMIT)
            pos = ACC_LIMIT;
        position_q = CFG_W'(pos);
    endtask

    task automatic send_sample(sample_t value);
        if (gaps_on && burst_left == 0)
        begin
            smp_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        smp_if.valid  <= 1'b1;
        smp_if.sample <= value;
        do
            @(posedge clk);
        while (smp_if.ready !== 1'b1);
        predict_words(value);
    endtask

    task automatic wait_drained();
        smp_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_words.size() != 0);
    endtask

    // Registers change only once the block has gone quiet.
    task automatic write_settings(logic [CFG_W-1:0] step_val, logic [COUNT_W-1:0] count_val);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_STEP_RATIO;
        cfg_data  <= step_val;
        @(posedge clk);
        cfg_index <= REG_CHANNEL_COUNT;
        cfg_data  <= CFG_W'(count_val);
        @(posedge clk);
        cfg_we          <= 1'b0;
        step_ratio_q    = step_val;
        channel_count_q = count_val;
    endtask

    task automatic test_default_setting();
        gaps_on = 1'b1;
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample(S_MIN);
        send_sample(S_MAX);
        send_sample('0);
        send_sample('1);
    endtask

    task automatic test_full_width_frames();
        write_settings(CFG_W'(8192), COUNT_W'(15));
        repeat (8) send_sample(rand_sample());
    endtask

    task automatic test_count_change_mid_frame();
        write_settings(CFG_W'(98304), COUNT_W'(4));
        send_sample(S_MIN);
        send_sample(S_MAX);
        send_sample(sample_t'(16'h1234));
        write_settings(CFG_W'(98304), COUNT_W'(2));
        send_sample(sample_t'(16'hA5A5));
        send_sample(S_MAX);
        send_sample(S_MIN);
    endtask

    task automatic test_step_floor();
        write_settings('0, '0);
        send_sample(16'sh0001);
        send_sample('1);
    endtask

    task automatic test_backpressure();
        write_settings(CFG_W'(8192), COUNT_W'(1));
        gaps_on      = 1'b0;
        hold_request = LONG_HOLD;
        repeat (40) send_sample(rand_sample());
        wait_drained();
        gaps_on = 1'b1;
        repeat (10) send_sample(rand_sample());
    endtask

    task automatic test_random_settings();
        int                 sent;
        int                 len;
        logic [CFG_W-1:0]   step_val;
        logic [COUNT_W-1:0] count_val;
        sent = 0;
        write_settings(CFG_W'(1048576), COUNT_W'(9));
        while (sent < RANDOM_ITEMS)
        begin
            len     = $urandom_range(10, 30);
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat (len) send_sample(rand_sample());
            sent += len;
            case ($urandom_range(0, 5))
                0:       step_val = CFG_W'(8192);
                1:       step_val = CFG_W'(1048576);
                2:       step_val = CFG_W'(65536);
                3:       step_val = CFG_W'($urandom_range(8192, 1048576));
                default: step_val = CFG_W'($urandom_range(32768, 131072));
            endcase
            if ($urandom_range(0, 7) == 0)
                count_val = COUNT_W'($urandom_range(0, 15));
            else
                count_val = COUNT_W'($urandom_range(1, 8));
            write_settings(step_val, count_val);
        end
        write_settings(STEP_MAX, COUNT_W'(1));
        gaps_on = 1'b1;
        repeat (12) send_sample(rand_sample());
    endtask

    initial
    begin
        interp_word_t w;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1)
            begin
                if (pending_words.size() == 0)
                begin
                    $error("unexpected word: out_sample %0d channel %0d last %0d",
                           res_if.out_sample, res_if.channel, res_if.last);
                    error_count++;
                end
                else
                begin
                    w = pending_words.pop_front();
                    if (res_if.out_sample !== w.value)
                    begin
                        $error("out_sample: expected %0d, actual %0d",
                               w.value, res_if.out_sample);
                        error_count++;
                    end
                    if (res_if.channel !== w.chan)
                    begin
                        $error("channel: expected %0d, actual %0d", w.chan, res_if.channel);
                        error_count++;
                    end
                    if (res_if.last !== w.last)
                    begin
                        $error("last: expected %0d, actual %0d", w.last, res_if.last);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        int         hold_left;
        int         stretch_left;
        int         bit_idx;
        logic [7:0] ready_pattern;
        res_if.ready  = 1'b0;
        hold_left     = 0;
        stretch_left  = 0;
        bit_idx       = 0;
        ready_pattern = '1;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                res_if.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    stretch_left = $urandom_range(8, 64);
                    if ($urandom_range(0, 2) == 0)
                        ready_pattern = 8'hFF;
                    else
                        ready_pattern = 8'($urandom) | 8'h01;
                end
                stretch_left--;
                res_if.ready <= ready_pattern[bit_idx];
                bit_idx = (bit_idx + 1) % 8;
            end
        end
    end

    initial
    begin
        cfg_we          = 1'b0;
        cfg_index       = REG_STEP_RATIO;
        cfg_data        = '0;
        smp_if.valid    = 1'b0;
        smp_if.sample   = '0;
        rst_n           = 1'b0;
        error_count     = 0;
        hold_request    = 0;
        burst_left      = 0;
        gaps_on         = 1'b0;
        step_ratio_q    = CFG_W'(65536);
        channel_count_q = CH_COUNT_RESET;
        chan_pos_q      = '0;
        position_q      = '0;
        frames_q        = '0;
        for (int i = 0; i < MAX_CHANNELS_DEF; i++)
        begin
            older_frame_q[i] = '0;
            newer_frame_q[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_setting();
        test_full_width_frames();
        test_count_change_mid_frame();
        test_step_floor();
        test_backpressure();
        test_random_settings();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### files.f
rtl/lir_pkg.sv
rtl/lir_if.sv
rtl/lir_front.sv
rtl/lir_queue.sv
rtl/lir_back.sv
rtl/linear_interp_audio_resampler.sv
rtl/lir_checker.sv
sim/tb_linear_interp_audio_resampler.sv
